>>> rtl/sn2d_pkg.sv
// Shared constants, types and table functions of the 2D simplex noise unit.
package sn2d_pkg;

   // Skew and unskew factors, Q.30, rounded to nearest
   localparam logic [28:0] F2_Q30   = 29'd393016785;
   localparam logic [27:0] G2_Q30   = 28'd226908346;
   localparam int          OFS_W    = 34;   // corner offset width, Q.30 signed
   localparam int          CELL_W   = 17;   // lattice cell coordinate width
   localparam int          GRAD_W   = 4;    // gradient index width
   localparam int          LAT_SKEW = 4;    // stages in the lattice front end
   localparam int          LAT_CORN = 4;    // stages in one corner unit
   localparam int          LAT_TOT  = LAT_SKEW + LAT_CORN + 2;

   // Permutation table of the hash
   localparam logic [7:0] PERM_ROM [0:255] = '{
      8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95, 8'd96,
      8'd53, 8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30, 8'd69, 8'd142,
      8'd8, 8'd99, 8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190, 8'd6, 8'd148, 8'd247,
      8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62, 8'd94, 8'd252, 8'd219, 8'd203,
      8'd117, 8'd35, 8'd11, 8'd32, 8'd57, 8'd177, 8'd33, 8'd88, 8'd237, 8'd149, 8'd56,
      8'd87, 8'd174, 8'd20, 8'd125, 8'd136, 8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165,
      8'd71, 8'd134, 8'd139, 8'd48, 8'd27, 8'd166, 8'd77, 8'd146, 8'd158, 8'd231, 8'd83,
      8'd111, 8'd229, 8'd122, 8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41,
      8'd55, 8'd46, 8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54, 8'd65, 8'd25, 8'd63,
      8'd161, 8'd1, 8'd216, 8'd80, 8'd73, 8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89,
      8'd18, 8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
      8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217, 8'd226,
      8'd250, 8'd124, 8'd123, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126, 8'd255, 8'd82,
      8'd85, 8'd212, 8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16, 8'd58, 8'd17, 8'd182,
      8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213, 8'd119, 8'd248, 8'd152, 8'd2,
      8'd44, 8'd154, 8'd163, 8'd70, 8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43, 8'd172,
      8'd9, 8'd129, 8'd22, 8'd39, 8'd253, 8'd19, 8'd98, 8'd108, 8'd110, 8'd79, 8'd113,
      8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104, 8'd218, 8'd246, 8'd97, 8'd228,
      8'd251, 8'd34, 8'd242, 8'd193, 8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179,
      8'd162, 8'd241, 8'd81, 8'd51, 8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107,
      8'd49, 8'd192, 8'd214, 8'd31, 8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84,
      8'd204, 8'd176, 8'd115, 8'd121, 8'd50, 8'd45, 8'd127, 8'd4, 8'd150, 8'd254,
      8'd138, 8'd236, 8'd205, 8'd93, 8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243,
      8'd141, 8'd128, 8'd195, 8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180 };

   // One corner handed from the lattice front end to a corner unit
   typedef struct packed {
      logic signed [OFS_W-1:0] dx;
      logic signed [OFS_W-1:0] dy;
      logic [GRAD_W-1:0]       grad;
   } corner_in_type;

   // Hash value modulo the gradient count (conditional subtracts)
   function automatic logic [GRAD_W-1:0] grad_index(input logic [7:0] h);
      logic [7:0] v;
      begin
         v = h;
         if (v >= 8'd192) v = v - 8'd192;
         if (v >= 8'd96)  v = v - 8'd96;
         if (v >= 8'd48)  v = v - 8'd48;
         if (v >= 8'd24)  v = v - 8'd24;
         if (v >= 8'd12)  v = v - 8'd12;
         return v[GRAD_W-1:0];
      end
   endfunction

   // Gradient x part: +1, -1 or 0
   function automatic logic signed [1:0] grad_x(input logic [GRAD_W-1:0] g);
      begin
         if (g >= 4'd8) return 2'sd0;
         return g[0] ? -2'sd1 : 2'sd1;
      end
   endfunction

   // Gradient y part: +1, -1 or 0
   function automatic logic signed [1:0] grad_y(input logic [GRAD_W-1:0] g);
      begin
         if (g < 4'd4)  return g[1] ? -2'sd1 : 2'sd1;
         if (g < 4'd8)  return 2'sd0;
         return g[0] ? -2'sd1 : 2'sd1;
      end
   endfunction

endpackage

>>> rtl/simplex_noise_2d_unit.sv
// Top level of the 2D simplex noise unit: stream ports, pipeline control, final sum.
//
// Usage:
//   One point enters on the req_ channel per transaction: req_tdata carries
//   x_coord and y_coord, both signed Q16.16. One noise sample leaves on the
//   rsp_ channel per input transaction: rsp_tdata carries noise_value, signed
//   Q1.15, saturated at both ends. Results come out in input order.
// Throughput: one point per cycle while the receiver does not stall; the pipeline
//   has ten register stages (four lattice/hash, four per corner falloff, sum,
//   scale and round), and each stage holds one point.
// Reset: clears every stage's valid bit; no output is presented afterward
//   until a new point has passed all stages. There is no memory to clear.
// Stall: while rsp_tvalid is high and rsp_tready low, the whole pipeline
//   holds and req_tready is low; nothing is dropped or repeated. Empty
//   output slots never hold the pipeline.
module simplex_noise_2d_unit import sn2d_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] x_coord, [63:32] y_coord
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [15:0] noise_value
);

   logic                ce;
   logic [LAT_TOT-1:0]  vld_ff;
   corner_in_type       corners [3];
   logic signed [58:0]  terms [3];

   // pipeline advances unless a finished sample is held back
   assign ce         = !vld_ff[LAT_TOT-1] || rsp_tready;
   assign req_tready = ce;
   assign rsp_tvalid = vld_ff[LAT_TOT-1];

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= {vld_ff[LAT_TOT-2:0], req_tvalid};
      end
   end

   sn2d_lattice u_lattice (
      .clock      (clock),
      .ce         (ce),
      .x_coord    ($signed(req_tdata[31:0])),
      .y_coord    ($signed(req_tdata[63:32])),
      .corner_out (corners)
   );

   for (genvar c = 0; c < 3; c++) begin : g_corner
      sn2d_corner u_corner (
         .clock     (clock),
         .ce        (ce),
         .corner_in (corners[c]),
         .term      (terms[c])
      );
   end

   // sum of the three contributions, Q.60
   logic signed [60:0] sum_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         sum_ff <= 61'(terms[0]) + 61'(terms[1]) + 61'(terms[2]);
      end
   end

   // floor to Q.45, scale by 70, round to Q.15, saturate
   logic signed [45:0] sum_q45;
   logic signed [53:0] scaled;
   logic signed [53:0] rounded;
   logic signed [23:0] res;
   logic [15:0]        noise_in, noise_ff;

   assign sum_q45 = sum_ff[60:15];
   assign scaled  = (54'(sum_q45) <<< 6) + (54'(sum_q45) <<< 2) + (54'(sum_q45) <<< 1);
   assign rounded = scaled + 54'(1 << 29);
   assign res     = rounded[53:30];

   always_comb begin
      if (res > 24'sd32767)        noise_in = 16'h7fff;
      else if (res < -24'sd32768)  noise_in = 16'h8000;
      else                         noise_in = res[15:0];
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         noise_ff <= noise_in;
      end
   end

   assign rsp_tdata = noise_ff;

   // checks
   a_reset_clears: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("output valid after reset");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output stalled");

   a_stall_freezes_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(vld_ff))
      else $error("pipeline moved during stall");

   a_flow_delivers: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAT_TOT-2] && ce |=> rsp_tvalid)
      else $error("sample lost in last stage");

endmodule

>>> rtl/sn2d_lattice.sv
// Skew, cell floor, unskew, triangle choice and corner hashing (four stages).
module sn2d_lattice import sn2d_pkg::*; (
   input  logic                       clock,
   input  logic                       ce,
   input  logic signed [31:0]         x_coord,
   input  logic signed [31:0]         y_coord,
   output corner_in_type              corner_out [3]
);

   // stage 1: skew product
   logic signed [31:0] x1_ff, y1_ff;
   logic signed [61:0] skew_ff, skew_in;

   assign skew_in = 62'(33'(x_coord) + 33'(y_coord)) * 62'($signed({1'b0, F2_Q30}));

   always_ff @(posedge clock) begin
      if (ce) begin
         x1_ff   <= x_coord;
         y1_ff   <= y_coord;
         skew_ff <= skew_in;
      end
   end

   // stage 2: floor to lattice cell
   logic signed [62:0] xs, ys;
   logic signed [31:0] x2_ff, y2_ff;
   logic signed [CELL_W-1:0] i2_ff, j2_ff;

   assign xs = (63'(x1_ff) <<< 30) + 63'(skew_ff);
   assign ys = (63'(y1_ff) <<< 30) + 63'(skew_ff);

   always_ff @(posedge clock) begin
      if (ce) begin
         x2_ff <= x1_ff;
         y2_ff <= y1_ff;
         i2_ff <= xs[62:46];
         j2_ff <= ys[62:46];
      end
   end

   // stage 3: unskew to first-corner offsets, first hash level
   logic signed [CELL_W:0]   ij_sum;
   logic signed [46:0]       unskew;
   logic [OFS_W-1:0]         x0_in, y0_in;
   logic signed [OFS_W-1:0]  x0_ff, y0_ff;
   logic [7:0]               ii3_ff, pj0_ff, pj1_ff;

   assign ij_sum = (CELL_W+1)'(i2_ff) + (CELL_W+1)'(j2_ff);
   assign unskew = 47'(ij_sum) * 47'($signed({1'b0, G2_Q30}));
   assign x0_in  = {x2_ff[19:0], 14'd0} - {i2_ff[3:0], 30'd0} + unskew[OFS_W-1:0];
   assign y0_in  = {y2_ff[19:0], 14'd0} - {j2_ff[3:0], 30'd0} + unskew[OFS_W-1:0];

   always_ff @(posedge clock) begin
      if (ce) begin
         x0_ff  <= x0_in;
         y0_ff  <= y0_in;
         ii3_ff <= i2_ff[7:0];
         pj0_ff <= PERM_ROM[j2_ff[7:0]];
         pj1_ff <= PERM_ROM[j2_ff[7:0] + 8'd1];
      end
   end

   // stage 4: triangle choice, other corner offsets, gradient picks
   localparam logic [OFS_W-1:0] ONE_Q30 = OFS_W'(1) << 30;
   localparam logic [OFS_W-1:0] G2_EXT  = OFS_W'(G2_Q30);

   logic             upper;
   logic [7:0]       h0, h1, h2;
   corner_in_type    c_in [3];
   corner_in_type    c_ff [3];

   assign upper = (x0_ff > y0_ff);
   assign h0    = PERM_ROM[ii3_ff + pj0_ff];
   assign h1    = PERM_ROM[ii3_ff + {7'd0, upper} + (upper ? pj0_ff : pj1_ff)];
   assign h2    = PERM_ROM[ii3_ff + 8'd1 + pj1_ff];

   always_comb begin
      c_in[0].dx   = x0_ff;
      c_in[0].dy   = y0_ff;
      c_in[0].grad = grad_index(h0);
      c_in[1].dx   = x0_ff - (upper ? ONE_Q30 : '0) + G2_EXT;
      c_in[1].dy   = y0_ff - (upper ? '0 : ONE_Q30) + G2_EXT;
      c_in[1].grad = grad_index(h1);
      c_in[2].dx   = x0_ff - ONE_Q30 + (G2_EXT << 1);
      c_in[2].dy   = y0_ff - ONE_Q30 + (G2_EXT << 1);
      c_in[2].grad = grad_index(h2);
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         c_ff <= c_in;
      end
   end

   assign corner_out = c_ff;

endmodule

>>> rtl/sn2d_corner.sv
// Falloff and gradient contribution of one simplex corner (four stages).
module sn2d_corner import sn2d_pkg::*; (
   input  logic                clock,
   input  logic                ce,
   input  corner_in_type       corner_in,
   output logic signed [58:0]  term
);

   // stage 1: squared radius, falloff base, gradient dot product
   logic [OFS_W-1:0] mag_x, mag_y;
   logic [59:0]      sq_x, sq_y;
   logic [60:0]      r2_full;
   logic [30:0]      r2;
   logic             kill_in;
   logic signed [1:0] gx, gy;
   logic signed [OFS_W:0] px, py, dot_in;

   assign mag_x   = corner_in.dx[OFS_W-1] ? -corner_in.dx : corner_in.dx;
   assign mag_y   = corner_in.dy[OFS_W-1] ? -corner_in.dy : corner_in.dy;
   assign sq_x    = mag_x[29:0] * mag_x[29:0];
   assign sq_y    = mag_y[29:0] * mag_y[29:0];
   assign r2_full = 61'(sq_x) + 61'(sq_y);
   assign r2      = r2_full[60:30];
   // outside the falloff disk (also any offset of magnitude one or more)
   assign kill_in = (mag_x[OFS_W-1:30] != '0) || (mag_y[OFS_W-1:30] != '0)
                    || (r2 > 31'(1 << 29));

   assign gx = grad_x(corner_in.grad);
   assign gy = grad_y(corner_in.grad);

   always_comb begin
      case (gx)
         2'sd1:   px = (OFS_W+1)'(corner_in.dx);
         -2'sd1:  px = -((OFS_W+1)'(corner_in.dx));
         default: px = '0;
      endcase
      case (gy)
         2'sd1:   py = (OFS_W+1)'(corner_in.dy);
         -2'sd1:  py = -((OFS_W+1)'(corner_in.dy));
         default: py = '0;
      endcase
      dot_in = px + py;
   end

   logic [29:0]        t1_ff;
   logic               kill1_ff, kill2_ff, kill3_ff;
   logic signed [31:0] dot1_ff, dot2_ff, dot3_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         t1_ff    <= 30'(31'(1 << 29) - r2);
         kill1_ff <= kill_in;
         dot1_ff  <= dot_in[31:0];
      end
   end

   // stage 2: t squared
   logic [59:0] t1_sq;
   logic [28:0] t2_ff;

   assign t1_sq = t1_ff * t1_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         t2_ff    <= t1_sq[58:30];
         kill2_ff <= kill1_ff;
         dot2_ff  <= dot1_ff;
      end
   end

   // stage 3: t to the fourth
   logic [57:0] t2_sq;
   logic [26:0] t4_ff;

   assign t2_sq = t2_ff * t2_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         t4_ff    <= t2_sq[56:30];
         kill3_ff <= kill2_ff;
         dot3_ff  <= dot2_ff;
      end
   end

   // stage 4: weighted contribution, Q.60
   logic signed [58:0] term_in, term_ff;

   assign term_in = 59'($signed({1'b0, t4_ff})) * 59'(dot3_ff);

   always_ff @(posedge clock) begin
      if (ce) begin
         term_ff <= kill3_ff ? '0 : term_in;
      end
   end

   assign term = term_ff;

endmodule
